@@ src/cssk_pkg.sv @@
// shared types, constants and the sequencer program for the cube slice keystream block
`default_nettype none
package cssk_pkg;

	localparam int DEF_ROUNDS    = 5;
	localparam int DEF_CUBE_SIDE = 4;
	localparam int DEF_MAX_MOVES = 10;

	localparam int MOVE_W       = 6;
	localparam int MOVE_LIST_W  = 60;
	localparam int MOVE_COUNT_W = 4;
	localparam int CFG_ADDR_W   = 1;
	localparam int CFG_DATA_W   = 60;

	localparam logic [CFG_ADDR_W-1:0] REG_MOVE_LIST  = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MOVE_COUNT = 1'd1;

	localparam logic KIND_KEY  = 1'b0;
	localparam logic KIND_TEXT = 1'b1;

	localparam logic [1:0] AXIS_ROW   = 2'd0;
	localparam logic [1:0] AXIS_COL   = 2'd1;
	localparam logic [1:0] AXIS_LAYER = 2'd2;
	localparam logic [1:0] AXIS_SKIP  = 2'd3;

	localparam logic [1:0] DIR_CCW = 2'd0;
	localparam logic [1:0] DIR_CW  = 2'd1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] cipher_byte;
		logic       overflow;
		logic       end_of_message;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MCHK,
		ST_MSKIP,
		ST_READ,
		ST_SDRAIN,
		ST_WRITE,
		ST_MNEXT,
		ST_XOR,
		ST_XDRAIN,
		ST_DONE
	} step_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOT_GO,
		C_MOVES_DONE,
		C_MOVE_SKIP,
		C_SLICE_MORE,
		C_CUBE_MORE,
		C_ROUNDS_LEFT
	} cond_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_SLICE,
		RD_XOR
	} rd_kind_t;

	typedef struct packed {
		logic     busy;
		rd_kind_t rd_kind;
		logic     cube_wr;
		logic     elem_clr;
		logic     elem_inc;
		logic     move_clr;
		logic     move_inc;
		logic     round_clr;
		logic     round_inc;
	} ctl_t;

	typedef struct packed {
		ctl_t  ctl;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic moves_done;
		logic move_skip;
		logic slice_more;
		logic cube_more;
		logic rounds_left;
	} status_t;

	function automatic uword_t ucode(input step_t step);
		uword_t w;
		w = '0;
		w.ctl.busy = 1'b1;
		w.cond = C_NEVER;
		w.target = ST_IDLE;
		case (step)
			ST_IDLE: begin
				w.ctl.busy = 1'b0;
				w.ctl.elem_clr = 1'b1;
				w.ctl.move_clr = 1'b1;
				w.ctl.round_clr = 1'b1;
				w.cond = C_NOT_GO;
				w.target = ST_IDLE;
			end
			ST_MCHK: begin
				w.ctl.elem_clr = 1'b1;
				w.cond = C_MOVES_DONE;
				w.target = ST_XOR;
			end
			ST_MSKIP: begin
				w.cond = C_MOVE_SKIP;
				w.target = ST_MNEXT;
			end
			ST_READ: begin
				w.ctl.rd_kind = RD_SLICE;
				w.ctl.elem_inc = 1'b1;
				w.cond = C_SLICE_MORE;
				w.target = ST_READ;
			end
			ST_SDRAIN: begin
				w.ctl.elem_clr = 1'b1;
			end
			ST_WRITE: begin
				w.ctl.cube_wr = 1'b1;
				w.ctl.elem_inc = 1'b1;
				w.cond = C_SLICE_MORE;
				w.target = ST_WRITE;
			end
			ST_MNEXT: begin
				w.ctl.move_inc = 1'b1;
				w.ctl.elem_clr = 1'b1;
				w.cond = C_ALWAYS;
				w.target = ST_MCHK;
			end
			ST_XOR: begin
				w.ctl.rd_kind = RD_XOR;
				w.ctl.elem_inc = 1'b1;
				w.cond = C_CUBE_MORE;
				w.target = ST_XOR;
			end
			ST_XDRAIN: begin
				w.ctl.round_inc = 1'b1;
				w.ctl.move_clr = 1'b1;
				w.ctl.elem_clr = 1'b1;
				w.cond = C_ROUNDS_LEFT;
				w.target = ST_MCHK;
			end
			ST_DONE: begin
				w.cond = C_ALWAYS;
				w.target = ST_IDLE;
			end
			default: begin
				w.ctl.busy = 1'b0;
				w.cond = C_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

@@ src/cssk_seq.sv @@
// microcode sequencer: step counter, program table lookup and conditional jumps
`default_nettype none
module cssk_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire cssk_pkg::status_t status,
	output cssk_pkg::ctl_t         ctl
);

	cssk_pkg::step_t  pc_q;
	cssk_pkg::step_t  pc_next;
	cssk_pkg::uword_t uw;
	logic             take;

	assign uw = cssk_pkg::ucode(pc_q);

	always_comb begin
		case (uw.cond)
			cssk_pkg::C_NEVER:       take = 1'b0;
			cssk_pkg::C_ALWAYS:      take = 1'b1;
			cssk_pkg::C_NOT_GO:      take = !go;
			cssk_pkg::C_MOVES_DONE:  take = status.moves_done;
			cssk_pkg::C_MOVE_SKIP:   take = status.move_skip;
			cssk_pkg::C_SLICE_MORE:  take = status.slice_more;
			cssk_pkg::C_CUBE_MORE:   take = status.cube_more;
			cssk_pkg::C_ROUNDS_LEFT: take = status.rounds_left;
			default:                 take = 1'b0;
		endcase
		pc_next = take ? uw.target : cssk_pkg::step_t'(4'(pc_q) + 4'd1);
	end

	always_comb begin
		ctl = uw.ctl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= cssk_pkg::ST_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule
`default_nettype wire

@@ src/cssk_datapath.sv @@
// cube memory, slice buffer, keystream memory and the loop counters they use
`default_nettype none
module cssk_datapath #(
	parameter int CUBE_SIDE = cssk_pkg::DEF_CUBE_SIDE,
	parameter int ROUNDS    = cssk_pkg::DEF_ROUNDS,
	parameter int MAX_MOVES = cssk_pkg::DEF_MAX_MOVES
) (
	input  wire logic                                            clk,
	input  wire logic                                            arst_n,
	input  wire cssk_pkg::ctl_t                                  ctl,
	input  wire logic [cssk_pkg::MOVE_LIST_W-1:0]                move_list,
	input  wire logic [cssk_pkg::MOVE_COUNT_W-1:0]               move_count,
	input  wire logic                                            key_we,
	input  wire logic [$clog2(CUBE_SIDE*CUBE_SIDE*CUBE_SIDE)-1:0] key_addr,
	input  wire logic [7:0]                                      key_data,
	input  wire logic [$clog2(CUBE_SIDE*CUBE_SIDE*CUBE_SIDE)-1:0] text_addr,
	output cssk_pkg::status_t                                    status,
	output logic [7:0]                                           ks_rdata
);

	localparam int N2     = CUBE_SIDE * CUBE_SIDE;
	localparam int N3     = N2 * CUBE_SIDE;
	localparam int CW     = $clog2(CUBE_SIDE);
	localparam int SL_W   = $clog2(N2);
	localparam int ELEM_W = $clog2(N3);
	localparam int MCNT_W = $clog2(MAX_MOVES + 1);
	localparam int RND_W  = $clog2(ROUNDS + 1);

	localparam logic [CW-1:0]     SIDE_M1 = CW'(CUBE_SIDE - 1);
	localparam logic [ELEM_W-1:0] SIDE_E  = ELEM_W'(CUBE_SIDE);
	localparam logic [SL_W-1:0]   SIDE_S  = SL_W'(CUBE_SIDE);

	logic [CW-1:0]     r_q, c_q;
	logic [ELEM_W-1:0] p_q;
	logic [MCNT_W-1:0] move_q;
	logic [RND_W-1:0]  round_q;

	cssk_pkg::rd_kind_t rd_kind_s1;
	logic [SL_W-1:0]    slice_addr_s1;
	logic [ELEM_W-1:0]  p_s1;

	logic [7:0] cube_mem [N3];
	logic [7:0] ks_mem [N3];
	logic [7:0] slice_buf [N2];
	logic [7:0] cube_rdata_q;
	logic [7:0] ks_rdata_q;

	logic [cssk_pkg::MOVE_W-1:0]       cur_move;
	logic [1:0]                        axis, slc, dir;
	logic [cssk_pkg::MOVE_COUNT_W-1:0] count_eff;
	logic [ELEM_W-1:0]                 cur_idx;
	logic [CW-1:0]                     src_i, src_j;
	logic [SL_W-1:0]                   src_addr, dst_addr;
	logic                              cube_we;
	logic [ELEM_W-1:0]                 cube_waddr, cube_raddr, ks_raddr;
	logic [7:0]                        cube_wdata, ks_wdata;
	logic                              ks_we;

	function automatic logic [ELEM_W-1:0] cube_idx(input logic [1:0] ax,
		input logic [CW-1:0] s, input logic [CW-1:0] i, input logic [CW-1:0] j);
		logic [ELEM_W-1:0] a, b, d;
		case (ax)
			cssk_pkg::AXIS_ROW: begin
				a = ELEM_W'(s);
				b = ELEM_W'(i);
				d = ELEM_W'(j);
			end
			cssk_pkg::AXIS_COL: begin
				a = ELEM_W'(i);
				b = ELEM_W'(s);
				d = ELEM_W'(j);
			end
			default: begin
				a = ELEM_W'(i);
				b = ELEM_W'(j);
				d = ELEM_W'(s);
			end
		endcase
		return (a * SIDE_E + b) * SIDE_E + d;
	endfunction

	assign cur_move = cssk_pkg::MOVE_W'(move_list >> (cssk_pkg::MOVE_W * move_q));
	assign axis = cur_move[5:4];
	assign slc  = cur_move[3:2];
	assign dir  = cur_move[1:0];

	assign count_eff = (move_count > cssk_pkg::MOVE_COUNT_W'(MAX_MOVES))
		? cssk_pkg::MOVE_COUNT_W'(MAX_MOVES) : move_count;

	assign status.moves_done  = cssk_pkg::MOVE_COUNT_W'(move_q) >= count_eff;
	assign status.move_skip   = (axis == cssk_pkg::AXIS_SKIP) || ({1'b0, slc} >= 3'(CUBE_SIDE));
	assign status.slice_more  = !((r_q == SIDE_M1) && (c_q == SIDE_M1));
	assign status.cube_more   = p_q != ELEM_W'(N3 - 1);
	assign status.rounds_left = round_q != RND_W'(ROUNDS - 1);

	assign cur_idx = cube_idx(axis, CW'(slc), r_q, c_q);

	// rotated source inside the slice
	always_comb begin
		case (dir)
			cssk_pkg::DIR_CW: begin
				src_i = c_q;
				src_j = SIDE_M1 - r_q;
			end
			cssk_pkg::DIR_CCW: begin
				src_i = SIDE_M1 - c_q;
				src_j = r_q;
			end
			default: begin
				src_i = c_q;
				src_j = r_q;
			end
		endcase
	end

	assign src_addr = SL_W'(src_i) * SIDE_S + SL_W'(src_j);
	assign dst_addr = SL_W'(r_q) * SIDE_S + SL_W'(c_q);

	assign cube_we    = key_we | ctl.cube_wr;
	assign cube_waddr = key_we ? key_addr : cur_idx;
	assign cube_wdata = key_we ? key_data : slice_buf[src_addr];
	assign cube_raddr = (ctl.rd_kind == cssk_pkg::RD_XOR) ? p_q : cur_idx;

	assign ks_we    = rd_kind_s1 == cssk_pkg::RD_XOR;
	assign ks_wdata = ((round_q == '0) ? 8'h00 : ks_rdata_q) ^ cube_rdata_q;
	assign ks_raddr = ctl.busy ? p_q : text_addr;
	assign ks_rdata = ks_rdata_q;

	always_ff @(posedge clk) begin
		if (cube_we) begin
			cube_mem[cube_waddr] <= cube_wdata;
		end
		cube_rdata_q <= cube_mem[cube_raddr];
	end

	always_ff @(posedge clk) begin
		if (ks_we) begin
			ks_mem[p_s1] <= ks_wdata;
		end
		ks_rdata_q <= ks_mem[ks_raddr];
	end

	always_ff @(posedge clk) begin
		if (rd_kind_s1 == cssk_pkg::RD_SLICE) begin
			slice_buf[slice_addr_s1] <= cube_rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		slice_addr_s1 <= dst_addr;
		p_s1 <= p_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
			p_q <= '0;
			move_q <= '0;
			round_q <= '0;
			rd_kind_s1 <= cssk_pkg::RD_NONE;
		end else begin
			rd_kind_s1 <= ctl.rd_kind;
			if (ctl.elem_clr) begin
				r_q <= '0;
				c_q <= '0;
				p_q <= '0;
			end else if (ctl.elem_inc) begin
				p_q <= p_q + 1'b1;
				if (c_q == SIDE_M1) begin
					c_q <= '0;
					r_q <= r_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
			if (ctl.move_clr) begin
				move_q <= '0;
			end else if (ctl.move_inc) begin
				move_q <= move_q + 1'b1;
			end
			if (ctl.round_clr) begin
				round_q <= '0;
			end else if (ctl.round_inc) begin
				round_q <= round_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/cube_slice_rotation_keystream_xor.sv @@
// top level of the cube slice rotation keystream cipher
`default_nettype none
// Key bytes (kind 0) and plaintext bytes (kind 1) are taken one per cycle while busy is low;
// each plaintext byte gives one result, shown with result_valid for one cycle in the cycle
// after its transfer, and the receiver cannot hold it off. The key byte marked last starts
// keystream generation, run by the microcode sequencer over the cube memory, which has a
// single read and a single write port; busy stays high until it is done. Moves with the
// skip axis or a slice out of range are skipped without touching the cube. Configuration
// writes must be made while idle.
module cube_slice_rotation_keystream_xor #(
	parameter int ROUNDS    = cssk_pkg::DEF_ROUNDS,
	parameter int CUBE_SIDE = cssk_pkg::DEF_CUBE_SIDE,
	parameter int MAX_MOVES = cssk_pkg::DEF_MAX_MOVES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire cssk_pkg::in_item_t                item,
	output logic                                   result_valid,
	output cssk_pkg::out_item_t                    result,
	input  wire logic                              cfg_we,
	input  wire logic [cssk_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [cssk_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int N3     = CUBE_SIDE * CUBE_SIDE * CUBE_SIDE;
	localparam int ELEM_W = $clog2(N3);
	localparam int POS_W  = $clog2(N3 + 1);

	logic [cssk_pkg::MOVE_LIST_W-1:0]  move_list_q;
	logic [cssk_pkg::MOVE_COUNT_W-1:0] move_count_q;
	logic [POS_W-1:0]                  key_pos_q, text_pos_q;
	logic                              ks_valid_q;
	logic                              res_valid_s1, ovf_s1, eom_s1;
	logic [7:0]                        byte_s1;

	cssk_pkg::ctl_t    ctl;
	cssk_pkg::status_t status;
	logic              accept, key_acc, text_acc, go, key_room, text_room;
	logic [7:0]        ks_rdata;

	assign accept    = start && !busy;
	assign key_acc   = accept && (item.kind == cssk_pkg::KIND_KEY);
	assign text_acc  = accept && (item.kind == cssk_pkg::KIND_TEXT);
	assign go        = key_acc && item.last;
	assign key_room  = key_pos_q < POS_W'(N3);
	assign text_room = text_pos_q < POS_W'(N3);
	assign busy      = ctl.busy;

	cssk_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.status (status),
		.ctl    (ctl)
	);

	cssk_datapath #(
		.CUBE_SIDE (CUBE_SIDE),
		.ROUNDS    (ROUNDS),
		.MAX_MOVES (MAX_MOVES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.move_list  (move_list_q),
		.move_count (move_count_q),
		.key_we     (key_acc && key_room),
		.key_addr   (key_pos_q[ELEM_W-1:0]),
		.key_data   (item.data_byte),
		.text_addr  (text_pos_q[ELEM_W-1:0]),
		.status     (status),
		.ks_rdata   (ks_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_list_q <= '0;
			move_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				cssk_pkg::REG_MOVE_LIST:  move_list_q <= cfg_wdata[cssk_pkg::MOVE_LIST_W-1:0];
				cssk_pkg::REG_MOVE_COUNT: move_count_q <= cfg_wdata[cssk_pkg::MOVE_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pos_q <= '0;
			text_pos_q <= '0;
			ks_valid_q <= 1'b0;
			res_valid_s1 <= 1'b0;
		end else begin
			res_valid_s1 <= text_acc;
			if (go) begin
				key_pos_q <= '0;
				text_pos_q <= '0;
				ks_valid_q <= 1'b1;
			end else if (key_acc && key_room) begin
				key_pos_q <= key_pos_q + 1'b1;
			end
			if (text_acc) begin
				if (item.last) begin
					text_pos_q <= '0;
				end else if (text_room) begin
					text_pos_q <= text_pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text_acc) begin
			byte_s1 <= item.data_byte;
			ovf_s1 <= !text_room;
			eom_s1 <= item.last;
		end
	end

	always_comb begin
		result.cipher_byte = ovf_s1 ? 8'h00 : (byte_s1 ^ (ks_valid_q ? ks_rdata : 8'h00));
		result.overflow = ovf_s1;
		result.end_of_message = eom_s1;
	end

	assign result_valid = res_valid_s1;

	a_result_follows_text: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(text_acc))
		else $error("result without a plaintext transfer");

	a_go_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> busy)
		else $error("keystream generation did not start");

	a_no_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !result_valid)
		else $error("result during keystream generation");

	a_text_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		text_pos_q <= POS_W'(N3) && key_pos_q <= POS_W'(N3))
		else $error("position counter past the cube size");

endmodule
`default_nettype wire
